/* rtl/core/tgl_pkg.sv */
// ----------------------------------------------------------------------------
// tgl_pkg
// Shared types and constants of the text glyph layout block: register
// indexes, glyph sources, GB2312 ranges and the punctuation code table.
// ----------------------------------------------------------------------------
package tgl_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int QDEPTH         = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_FIRST_CODE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_LAST_CODE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HANZI_ENABLE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MONO_PANEL      = 3'd7;

	// reset values of the registers
	localparam int SCREEN_WIDTH_RST  = 128;
	localparam int SCREEN_HEIGHT_RST = 64;
	localparam logic [7:0]  FONT_WIDTH_RST      = 8'd8;
	localparam logic [7:0]  FONT_HEIGHT_RST     = 8'd16;
	localparam logic [15:0] FONT_FIRST_CODE_RST = 16'd32;
	localparam logic [15:0] FONT_LAST_CODE_RST  = 16'd126;
	localparam logic [7:0]  LINE_HEIGHT_RST     = 8'd16;

	// glyph sources
	localparam logic [1:0] SRC_BLANK = 2'd0;
	localparam logic [1:0] SRC_FONT  = 2'd1;
	localparam logic [1:0] SRC_MAIN  = 2'd2;
	localparam logic [1:0] SRC_PUNCT = 2'd3;

	// GB2312 ranges
	localparam logic [15:0] HZ_CODE_MIN  = 16'hA0A0;
	localparam logic [7:0]  HZ_LEAD_MIN  = 8'hB0;
	localparam logic [7:0]  HZ_LEAD_MAX  = 8'hF7;
	localparam logic [7:0]  HZ_TRAIL_MIN = 8'hA1;
	localparam logic [7:0]  HZ_TRAIL_MAX = 8'hFE;
	localparam logic [12:0] HZ_ROW_LEN   = 13'd94;
	localparam logic [15:0] HZ_MAIN_COUNT = 16'd6768;

	localparam logic [7:0] HZ_SIZE    = 8'd16;
	localparam logic [7:0] MONO_SIZE  = 8'd14;
	localparam logic [7:0] MONO_STEP  = 8'd16;

	localparam logic [7:0] CHAR_QMARK = 8'h3F;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	localparam int PUNCT_N = 30;
	localparam logic [15:0] PUNCT_CODES [PUNCT_N] = '{
		16'hA1A2, 16'hA1A3, 16'hA1AA, 16'hA1AD, 16'hA1AE, 16'hA1AF, 16'hA1B0, 16'hA1B1,
		16'hA1B2, 16'hA1B3, 16'hA1B4, 16'hA1B5, 16'hA1B6, 16'hA1B7, 16'hA1B8, 16'hA1B9,
		16'hA1BA, 16'hA1BB, 16'hA1BE, 16'hA1BF, 16'hA3A1, 16'hA3A8, 16'hA3A9, 16'hA3AC,
		16'hA3AD, 16'hA3AE, 16'hA3BA, 16'hA3BB, 16'hA3BF, 16'hE0C5
	};

	typedef struct packed {
		logic [7:0]  width;
		logic [7:0]  height;
		logic [15:0] first_code;
		logic [15:0] last_code;
		logic        hanzi_en;
	} font_cfg_t;

	typedef struct packed {
		logic [1:0]  src;
		logic [15:0] idx;
		logic [7:0]  w;
		logic [7:0]  h;
	} glyph_t;

endpackage

/* rtl/core/tgl_in_if.sv */
// ----------------------------------------------------------------------------
// tgl_in_if
// Text byte channel: valid/ready handshake with one text byte per item.
// ----------------------------------------------------------------------------
interface tgl_in_if #(
	parameter int COORD_BITS = tgl_pkg::COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [7:0]            text_byte;
	logic                  first_byte;
	logic                  last_byte;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;

	modport source (
		output valid, text_byte, first_byte, last_byte, start_x, start_y,
		input  ready
	);
	modport sink (
		input  valid, text_byte, first_byte, last_byte, start_x, start_y,
		output ready
	);
	modport monitor (
		input valid, ready, text_byte, first_byte, last_byte, start_x, start_y
	);
endinterface

/* rtl/core/tgl_out_if.sv */
// ----------------------------------------------------------------------------
// tgl_out_if
// Glyph placement channel: valid/ready handshake with one placement per item.
// ----------------------------------------------------------------------------
interface tgl_out_if #(
	parameter int COORD_BITS = tgl_pkg::COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            glyph_source;
	logic [15:0]           glyph_index;
	logic [COORD_BITS-1:0] place_x;
	logic [COORD_BITS-1:0] place_y;
	logic [7:0]            glyph_width;
	logic [7:0]            glyph_height;
	logic                  run_end;

	modport source (
		output valid, glyph_source, glyph_index, place_x, place_y,
		       glyph_width, glyph_height, run_end,
		input  ready
	);
	modport sink (
		input  valid, glyph_source, glyph_index, place_x, place_y,
		       glyph_width, glyph_height, run_end,
		output ready
	);
	modport monitor (
		input valid, ready, glyph_source, glyph_index, place_x, place_y,
		      glyph_width, glyph_height, run_end
	);
endinterface

/* rtl/core/tgl_glyph_pick.sv */
// ----------------------------------------------------------------------------
// tgl_glyph_pick
// Maps a character code to glyph source, index and size: GB2312 main area,
// punctuation table, small font range or blank.
// ----------------------------------------------------------------------------
module tgl_glyph_pick (
	input  logic [15:0]        code,
	input  tgl_pkg::font_cfg_t fcfg,
	output tgl_pkg::glyph_t    glyph
);

	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [6:0]  row;
	logic [7:0]  col;
	logic [12:0] main_idx;
	logic        in_main;
	logic        punct_hit;
	logic [4:0]  punct_idx;

	assign b1 = code[15:8];
	assign b2 = code[7:0];
	assign row = 7'(b1 - tgl_pkg::HZ_LEAD_MIN);
	assign col = b2 - tgl_pkg::HZ_TRAIL_MIN;
	assign main_idx = 13'(row) * tgl_pkg::HZ_ROW_LEN + 13'(col);
	assign in_main = (b1 >= tgl_pkg::HZ_LEAD_MIN) && (b1 <= tgl_pkg::HZ_LEAD_MAX) &&
	                 (b2 >= tgl_pkg::HZ_TRAIL_MIN) && (b2 <= tgl_pkg::HZ_TRAIL_MAX);

	// parallel compare against the punctuation codes
	always_comb begin
		punct_hit = 1'b0;
		punct_idx = '0;
		for (int i = tgl_pkg::PUNCT_N - 1; i >= 0; i--) begin
			if (code == tgl_pkg::PUNCT_CODES[i]) begin
				punct_hit = 1'b1;
				punct_idx = 5'(i);
			end
		end
	end

	always_comb begin
		glyph.src = tgl_pkg::SRC_BLANK;
		glyph.idx = '0;
		if (code >= tgl_pkg::HZ_CODE_MIN) begin
			glyph.w = tgl_pkg::HZ_SIZE;
			glyph.h = tgl_pkg::HZ_SIZE;
			if (fcfg.hanzi_en) begin
				if (in_main) begin
					glyph.src = tgl_pkg::SRC_MAIN;
					glyph.idx = 16'(main_idx);
				end else if (punct_hit) begin
					glyph.src = tgl_pkg::SRC_PUNCT;
					glyph.idx = 16'(punct_idx);
				end
			end
		end else begin
			glyph.w = fcfg.width;
			glyph.h = fcfg.height;
			if (code >= fcfg.first_code && code <= fcfg.last_code) begin
				glyph.src = tgl_pkg::SRC_FONT;
				glyph.idx = code - fcfg.first_code;
			end
		end
	end

endmodule

/* rtl/core/tgl_advance.sv */
// ----------------------------------------------------------------------------
// tgl_advance
// Places one glyph at the cursor and computes the next cursor position with
// right-edge and bottom wrap, including the mono 14x14 offset rule.
// ----------------------------------------------------------------------------
module tgl_advance #(
	parameter int COORD_BITS = tgl_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0] cur_x,
	input  logic [COORD_BITS-1:0] cur_y,
	input  tgl_pkg::glyph_t       glyph,
	input  logic                  mono,
	input  logic [COORD_BITS-1:0] screen_w,
	input  logic [COORD_BITS-1:0] screen_h,
	output logic [COORD_BITS-1:0] place_x,
	output logic [COORD_BITS-1:0] place_y,
	output logic [COORD_BITS-1:0] next_x,
	output logic [COORD_BITS-1:0] next_y,
	output logic [7:0]            adv_h
);

	logic              mono14;
	logic [7:0]        adv_w;
	logic [COORD_BITS:0] sum_x;
	logic [COORD_BITS:0] down_y;
	logic [COORD_BITS:0] row_y;

	assign mono14 = mono && (glyph.w == tgl_pkg::MONO_SIZE) && (glyph.h == tgl_pkg::MONO_SIZE);
	assign adv_w = mono14 ? tgl_pkg::MONO_STEP : glyph.w;
	assign adv_h = mono14 ? tgl_pkg::MONO_STEP : glyph.h;

	assign place_x = cur_x + COORD_BITS'(mono14);
	assign place_y = cur_y + COORD_BITS'(mono14);

	assign sum_x  = {1'b0, cur_x} + (COORD_BITS+1)'(adv_w);
	assign down_y = {1'b0, cur_y} + (COORD_BITS+1)'(adv_h);

	always_comb begin
		if (sum_x >= {1'b0, screen_w}) begin
			next_x = '0;
			row_y  = down_y;
		end else begin
			next_x = sum_x[COORD_BITS-1:0];
			row_y  = {1'b0, cur_y};
		end
		// bottom wrap
		next_y = (row_y >= {1'b0, screen_h}) ? '0 : row_y[COORD_BITS-1:0];
	end

endmodule

/* rtl/core/text_glyph_layout.sv */
// ----------------------------------------------------------------------------
// text_glyph_layout
// GB2312 text layout: turns a byte stream into glyph placements.
// ----------------------------------------------------------------------------
// One text byte is taken per clock while the input is ready. A byte is held
// in an input register, its placements (none, one or two) are worked out in
// that cycle and pushed into a four-entry result queue that feeds the output
// channel, which moves one placement per clock while the sink is ready. The
// input is ready while the input register is empty or its item can move on,
// which needs two free queue entries; with the output always ready the block
// sustains one byte per cycle; a byte that yields two placements (a lone lead
// byte then a 7-bit non-break byte) pushes both at once. Bytes pass the input
// register, then the queue. Registers take effect on the next item; the user
// must write them only while no item is in flight: the block does not check.
module text_glyph_layout #(
	parameter int COORD_BITS = tgl_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tgl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgl_pkg::CFG_DATA_W-1:0] cfg_data,
	tgl_in_if.sink                         text,
	tgl_out_if.source                      glyph
);

	localparam int QW    = $clog2(tgl_pkg::QDEPTH);
	localparam int CNT_W = $clog2(tgl_pkg::QDEPTH + 1);

	typedef struct packed {
		logic [1:0]            src;
		logic [15:0]           idx;
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic [7:0]            w;
		logic [7:0]            h;
		logic                  run_end;
	} res_t;

	// registers
	logic [COORD_BITS-1:0] screen_w_q, screen_h_q;
	tgl_pkg::font_cfg_t    fcfg_q;
	logic                  mono_q;

	// cursor state
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic [7:0]            lead_q;
	logic                  pend_q;
	logic [7:0]            line_h_q;

	// input register
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  first_s1, last_s1;
	logic [COORD_BITS-1:0] sx_s1, sy_s1;

	// result queue
	res_t                  q_mem_q [tgl_pkg::QDEPTH];
	logic [QW-1:0]         wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  adv, pop;
	logic [COORD_BITS-1:0] cx0, cy0;
	logic                  pend0;
	logic                  has_a, has_b, consumed, is_br;
	logic [15:0]           code_a, code_b;
	tgl_pkg::glyph_t       g_a, g_b;
	logic [COORD_BITS-1:0] pax, pay, nax, nay, pbx, pby, nbx, nby;
	logic [7:0]            ah_a, ah_b;
	logic [COORD_BITS-1:0] cx1, cy1;
	logic [7:0]            lh1;
	logic [COORD_BITS:0]   br_y;
	logic [COORD_BITS-1:0] cx_n, cy_n;
	logic [7:0]            lh_n;
	logic                  pend_n;
	res_t                  res_a, res_b;
	logic [1:0]            n_push;

	assign adv        = valid_s1 && (cnt_q <= CNT_W'(tgl_pkg::QDEPTH - 2));
	assign text.ready = !valid_s1 || adv;
	assign pop        = glyph.valid && glyph.ready;

	// start position load
	assign cx0   = first_s1 ? ((sx_s1 >= screen_w_q) ? '0 : sx_s1) : cur_x_q;
	assign cy0   = first_s1 ? ((sy_s1 >= screen_h_q) ? '0 : sy_s1) : cur_y_q;
	assign pend0 = pend_q && !first_s1;

	// pending lead byte: a hanzi pair or a lone '?'
	assign has_a    = pend0;
	assign code_a   = byte_s1[7] ? {lead_q, byte_s1} : {8'h00, tgl_pkg::CHAR_QMARK};
	assign consumed = pend0 && byte_s1[7];
	assign is_br    = (byte_s1 == tgl_pkg::CHAR_CR) || (byte_s1 == tgl_pkg::CHAR_LF);
	assign has_b    = !consumed && !is_br && (!byte_s1[7] || last_s1);
	assign code_b   = byte_s1[7] ? {8'h00, tgl_pkg::CHAR_QMARK} : {8'h00, byte_s1};
	assign pend_n   = !consumed && byte_s1[7] && !last_s1;

	tgl_glyph_pick u_pick_a (.code(code_a), .fcfg(fcfg_q), .glyph(g_a));
	tgl_glyph_pick u_pick_b (.code(code_b), .fcfg(fcfg_q), .glyph(g_b));

	tgl_advance #(.COORD_BITS(COORD_BITS)) u_adv_a (
		.cur_x(cx0), .cur_y(cy0), .glyph(g_a), .mono(mono_q),
		.screen_w(screen_w_q), .screen_h(screen_h_q),
		.place_x(pax), .place_y(pay), .next_x(nax), .next_y(nay), .adv_h(ah_a)
	);

	assign cx1 = has_a ? nax : cx0;
	assign cy1 = has_a ? nay : cy0;
	assign lh1 = has_a ? ah_a : line_h_q;

	tgl_advance #(.COORD_BITS(COORD_BITS)) u_adv_b (
		.cur_x(cx1), .cur_y(cy1), .glyph(g_b), .mono(mono_q),
		.screen_w(screen_w_q), .screen_h(screen_h_q),
		.place_x(pbx), .place_y(pby), .next_x(nbx), .next_y(nby), .adv_h(ah_b)
	);

	// line break uses the height of the last placed glyph
	assign br_y = {1'b0, cy1} + (COORD_BITS+1)'(lh1);

	always_comb begin
		if (has_b) begin
			cx_n = nbx;
			cy_n = nby;
			lh_n = ah_b;
		end else if (!consumed && is_br) begin
			cx_n = '0;
			cy_n = (br_y >= {1'b0, screen_h_q}) ? '0 : br_y[COORD_BITS-1:0];
			lh_n = lh1;
		end else begin
			cx_n = cx1;
			cy_n = cy1;
			lh_n = lh1;
		end
	end

	always_comb begin
		res_a = '{src: g_a.src, idx: g_a.idx, px: pax, py: pay,
		          w: g_a.w, h: g_a.h, run_end: !has_b};
		res_b = '{src: g_b.src, idx: g_b.idx, px: pbx, py: pby,
		          w: g_b.w, h: g_b.h, run_end: 1'b1};
	end

	assign n_push = {1'b0, has_a} + {1'b0, has_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= COORD_BITS'(tgl_pkg::SCREEN_WIDTH_RST);
			screen_h_q <= COORD_BITS'(tgl_pkg::SCREEN_HEIGHT_RST);
			fcfg_q     <= '{width: tgl_pkg::FONT_WIDTH_RST, height: tgl_pkg::FONT_HEIGHT_RST,
			                first_code: tgl_pkg::FONT_FIRST_CODE_RST,
			                last_code: tgl_pkg::FONT_LAST_CODE_RST, hanzi_en: 1'b1};
			mono_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tgl_pkg::CFG_SCREEN_WIDTH:    screen_w_q <= cfg_data[COORD_BITS-1:0];
				tgl_pkg::CFG_SCREEN_HEIGHT:   screen_h_q <= cfg_data[COORD_BITS-1:0];
				tgl_pkg::CFG_FONT_WIDTH:      fcfg_q.width <= cfg_data[7:0];
				tgl_pkg::CFG_FONT_HEIGHT:     fcfg_q.height <= cfg_data[7:0];
				tgl_pkg::CFG_FONT_FIRST_CODE: fcfg_q.first_code <= cfg_data[15:0];
				tgl_pkg::CFG_FONT_LAST_CODE:  fcfg_q.last_code <= cfg_data[15:0];
				tgl_pkg::CFG_HANZI_ENABLE:    fcfg_q.hanzi_en <= cfg_data[0];
				tgl_pkg::CFG_MONO_PANEL:      mono_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1  <= text.text_byte;
			first_s1 <= text.first_byte;
			last_s1  <= text.last_byte;
			sx_s1    <= text.start_x;
			sy_s1    <= text.start_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			lead_q   <= '0;
			pend_q   <= 1'b0;
			line_h_q <= tgl_pkg::LINE_HEIGHT_RST;
		end else if (adv) begin
			cur_x_q  <= cx_n;
			cur_y_q  <= cy_n;
			line_h_q <= lh_n;
			pend_q   <= pend_n;
			if (pend_n) begin
				lead_q <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (has_a) begin
				q_mem_q[wr_ptr_q] <= res_a;
			end
			if (has_b) begin
				q_mem_q[has_a ? wr_ptr_q + QW'(1) : wr_ptr_q] <= res_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + QW'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			cnt_q <= cnt_q + (adv ? CNT_W'(n_push) : '0) - CNT_W'(pop);
		end
	end

	assign glyph.valid        = (cnt_q != '0);
	assign glyph.glyph_source = q_mem_q[rd_ptr_q].src;
	assign glyph.glyph_index  = q_mem_q[rd_ptr_q].idx;
	assign glyph.place_x      = q_mem_q[rd_ptr_q].px;
	assign glyph.place_y      = q_mem_q[rd_ptr_q].py;
	assign glyph.glyph_width  = q_mem_q[rd_ptr_q].w;
	assign glyph.glyph_height = q_mem_q[rd_ptr_q].h;
	assign glyph.run_end      = q_mem_q[rd_ptr_q].run_end;

endmodule

/* rtl/core/tgl_checker.sv */
// ----------------------------------------------------------------------------
// tgl_checker
// Port-level checks of the text glyph layout block, bound to the top level.
// ----------------------------------------------------------------------------
module tgl_checker (
	input logic       clk,
	input logic       arst_n,
	tgl_in_if.sink    text,
	tgl_out_if.source glyph
);

	// a placement waiting for the sink stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		glyph.valid && !glyph.ready |=> glyph.valid)
		else $error("placement dropped while stalled");

	// a blank glyph carries index zero
	a_blank_idx: assert property (@(posedge clk) disable iff (!arst_n)
		glyph.valid && glyph.glyph_source == tgl_pkg::SRC_BLANK |-> glyph.glyph_index == '0)
		else $error("blank glyph with nonzero index");

	// main hanzi area: 16x16 and index inside the 72x94 area
	a_main: assert property (@(posedge clk) disable iff (!arst_n)
		glyph.valid && glyph.glyph_source == tgl_pkg::SRC_MAIN |->
			glyph.glyph_index < tgl_pkg::HZ_MAIN_COUNT &&
			glyph.glyph_width == tgl_pkg::HZ_SIZE && glyph.glyph_height == tgl_pkg::HZ_SIZE)
		else $error("bad main hanzi placement");

	// punctuation: 16x16 and index inside the table
	a_punct: assert property (@(posedge clk) disable iff (!arst_n)
		glyph.valid && glyph.glyph_source == tgl_pkg::SRC_PUNCT |->
			glyph.glyph_index < 16'(tgl_pkg::PUNCT_N) &&
			glyph.glyph_width == tgl_pkg::HZ_SIZE && glyph.glyph_height == tgl_pkg::HZ_SIZE)
		else $error("bad punctuation placement");

endmodule

bind text_glyph_layout tgl_checker u_tgl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.text(text),
	.glyph(glyph)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the text glyph layout block against a behavioral predictor. Bytes
// go in as directed cases, then as random strings of ASCII, GB2312 pairs,
// punctuation codes, lone lead bytes and line breaks, plus noise, across
// several panel and font settings. Both channels idle at random, and the
// output is held off long enough at times to fill the block up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          CW            = tgl_pkg::COORD_BITS_DEF;
	localparam int unsigned COORD_MASK    = (1 << CW) - 1;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned RANDOM_ITEMS  = 1300;

	typedef struct packed {
		logic [1:0]    src;
		logic [15:0]   idx;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [7:0]    w;
		logic [7:0]    h;
		logic          run_end;
	} placement_t;

	typedef struct {
		int unsigned scr_w;
		int unsigned scr_h;
		int unsigned fnt_w;
		int unsigned fnt_h;
		int unsigned code_lo;
		int unsigned code_hi;
		bit          hz_en;
		bit          mono;
	} panel_cfg_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [tgl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tgl_pkg::CFG_DATA_W-1:0] cfg_data;

	tgl_in_if  #(.COORD_BITS(CW)) text_if ();
	tgl_out_if #(.COORD_BITS(CW)) glyph_if ();

	text_glyph_layout #(.COORD_BITS(CW)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text      (text_if),
		.glyph     (glyph_if)
	);

	// predictor copy of the panel settings and the layout state
	panel_cfg_t  panel;
	int unsigned cur_x = 0;
	int unsigned cur_y = 0;
	int unsigned line_h = tgl_pkg::LINE_HEIGHT_RST;
	logic [7:0]  lead_byte_q = 8'h00;
	bit          lead_wait = 1'b0;

	placement_t  pending_glyphs[$];
	placement_t  want_glyph;
	int unsigned error_count = 0;
	int unsigned glyphs_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	bit          steady_tx = 1'b0;

	bit [31:0]   rx_cycle = 0;
	int unsigned hold_left = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_done = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic void lookup_glyph(input int unsigned code, output logic [1:0] src,
			output logic [15:0] idx, output int unsigned w, output int unsigned h);
		int unsigned hi;
		int unsigned lo;
		hi = (code >> 8) & 8'hFF;
		lo = code & 8'hFF;
		src = tgl_pkg::SRC_BLANK;
		idx = 16'd0;
		if (code >= tgl_pkg::HZ_CODE_MIN) begin
			w = tgl_pkg::HZ_SIZE;
			h = tgl_pkg::HZ_SIZE;
			if (panel.hz_en) begin
				if (hi >= tgl_pkg::HZ_LEAD_MIN && hi <= tgl_pkg::HZ_LEAD_MAX &&
						lo >= tgl_pkg::HZ_TRAIL_MIN && lo <= tgl_pkg::HZ_TRAIL_MAX) begin
					src = tgl_pkg::SRC_MAIN;
					idx = 16'((hi - tgl_pkg::HZ_LEAD_MIN) * tgl_pkg::HZ_ROW_LEN + lo
						- tgl_pkg::HZ_TRAIL_MIN);
				end else begin
					for (int i = 0; i < tgl_pkg::PUNCT_N; i++) begin
						if (code == tgl_pkg::PUNCT_CODES[i]) begin
							src = tgl_pkg::SRC_PUNCT;
							idx = 16'(i);
						end
					end
				end
			end
		end else begin
			w = panel.fnt_w;
			h = panel.fnt_h;
			if (code >= panel.code_lo && code <= panel.code_hi) begin
				src = tgl_pkg::SRC_FONT;
				idx = 16'(code - panel.code_lo);
			end
		end
	endfunction

	function automatic void wrap_row();
		if (cur_y >= panel.scr_h)
			cur_y = 0;
		cur_y = cur_y & COORD_MASK;
	endfunction

	function automatic placement_t place_glyph(int unsigned code);
		placement_t  p;
		logic [1:0]  src;
		logic [15:0] idx;
		int unsigned w, h, aw, ah, px, py;
		lookup_glyph(code, src, idx, w, h);
		aw = w;
		ah = h;
		px = cur_x;
		py = cur_y;
		// 14x14 glyphs on a mono panel sit one pixel in and step as 16x16
		if (panel.mono && w == tgl_pkg::MONO_SIZE && h == tgl_pkg::MONO_SIZE) begin
			px = px + 1;
			py = py + 1;
			aw = tgl_pkg::MONO_STEP;
			ah = tgl_pkg::MONO_STEP;
		end
		p.src = src;
		p.idx = idx;
		p.x = px[CW-1:0];
		p.y = py[CW-1:0];
		p.w = w[7:0];
		p.h = h[7:0];
		p.run_end = 1'b0;
		if (cur_x + aw >= panel.scr_w) begin
			cur_y = cur_y + ah;
			cur_x = 0;
		end else begin
			cur_x = (cur_x + aw) & COORD_MASK;
		end
		wrap_row();
		line_h = ah & 8'hFF;
		return p;
	endfunction

	function automatic void predict_byte(logic [7:0] tbyte, bit is_first, bit is_last,
			logic [CW-1:0] sx, logic [CW-1:0] sy);
		placement_t  step_out[$];
		int unsigned b;
		b = tbyte;
		if (is_first) begin
			cur_x = (sx >= panel.scr_w) ? 0 : sx;
			cur_y = (sy >= panel.scr_h) ? 0 : sy;
			lead_wait = 1'b0;
		end
		if (lead_wait) begin
			lead_wait = 1'b0;
			if (tbyte[7]) begin
				step_out.push_back(place_glyph({lead_byte_q, tbyte}));
				b = 'h100;
			end else begin
				step_out.push_back(place_glyph(tgl_pkg::CHAR_QMARK));
			end
		end
		if (b < 'h100) begin
			if (b == tgl_pkg::CHAR_CR || b == tgl_pkg::CHAR_LF) begin
				cur_x = 0;
				cur_y = cur_y + line_h;
				wrap_row();
			end else if (tbyte[7]) begin
				if (is_last) begin
					step_out.push_back(place_glyph(tgl_pkg::CHAR_QMARK));
				end else begin
					lead_byte_q = tbyte;
					lead_wait = 1'b1;
				end
			end else begin
				step_out.push_back(place_glyph(b));
			end
		end
		if (step_out.size() != 0)
			step_out[step_out.size() - 1].run_end = 1'b1;
		foreach (step_out[i])
			pending_glyphs.push_back(step_out[i]);
	endfunction

	// ---------------- output side ----------------

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (!arst_n || hold_left != 0) begin
			glyph_if.ready <= 1'b0;
		end else begin
			case (rx_cycle[9:8])
				2'd0: glyph_if.ready <= 1'b1;
				2'd1: glyph_if.ready <= ($urandom_range(0, 99) < 75);
				2'd2: glyph_if.ready <= ($urandom_range(0, 99) < 25);
				default: glyph_if.ready <= (rx_cycle % 7 != 0);
			endcase
		end
	end

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("placement %0d %s: got 0x%0h, expected 0x%0h",
				glyphs_seen, name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && glyph_if.valid === 1'b1 && glyph_if.ready === 1'b1) begin
			if (pending_glyphs.size() == 0) begin
				report_mismatch($sformatf("unexpected placement src=%0d idx=%0d at (%0d,%0d)",
					glyph_if.glyph_source, glyph_if.glyph_index,
					glyph_if.place_x, glyph_if.place_y));
			end else begin
				want_glyph = pending_glyphs.pop_front();
				check_field("glyph_source", 32'(glyph_if.glyph_source), 32'(want_glyph.src));
				check_field("glyph_index", 32'(glyph_if.glyph_index), 32'(want_glyph.idx));
				check_field("place_x", 32'(glyph_if.place_x), 32'(want_glyph.x));
				check_field("place_y", 32'(glyph_if.place_y), 32'(want_glyph.y));
				check_field("glyph_width", 32'(glyph_if.glyph_width), 32'(want_glyph.w));
				check_field("glyph_height", 32'(glyph_if.glyph_height), 32'(want_glyph.h));
				check_field("run_end", 32'(glyph_if.run_end), 32'(want_glyph.run_end));
			end
			glyphs_seen++;
		end
	end

	// ---------------- input side ----------------

	task automatic send_byte(logic [7:0] tbyte, bit is_first, bit is_last,
			logic [CW-1:0] sx, logic [CW-1:0] sy);
		int unsigned gap;
		if (!steady_tx && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			text_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left != 0)
			burst_left--;
		text_if.valid      <= 1'b1;
		text_if.text_byte  <= tbyte;
		text_if.first_byte <= is_first;
		text_if.last_byte  <= is_last;
		text_if.start_x    <= sx;
		text_if.start_y    <= sy;
		do @(posedge clk); while (text_if.ready !== 1'b1);
		predict_byte(tbyte, is_first, is_last, sx, sy);
		items_sent++;
	endtask

	// a byte with don't-care start position
	task automatic send_plain(logic [7:0] tbyte, bit is_last);
		send_byte(tbyte, 1'b0, is_last, CW'($urandom_range(0, COORD_MASK)),
			CW'($urandom_range(0, COORD_MASK)));
	endtask

	// one string of random tokens, usually terminated, from a random start
	task automatic send_string(int unsigned tokens);
		logic [7:0]    text_bytes[$];
		logic [15:0]   code;
		logic [CW-1:0] sx, sy;
		int unsigned   r;
		bit            terminated;
		for (int t = 0; t < tokens; t++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				text_bytes.push_back(8'($urandom_range(32, 126)));
			end else if (r < 45) begin
				text_bytes.push_back(8'($urandom_range(0, 127)));
			end else if (r < 65) begin
				text_bytes.push_back(8'($urandom_range(tgl_pkg::HZ_LEAD_MIN,
					tgl_pkg::HZ_LEAD_MAX)));
				text_bytes.push_back(8'($urandom_range(tgl_pkg::HZ_TRAIL_MIN,
					tgl_pkg::HZ_TRAIL_MAX)));
			end else if (r < 75) begin
				code = tgl_pkg::PUNCT_CODES[$urandom_range(0, tgl_pkg::PUNCT_N - 1)];
				text_bytes.push_back(code[15:8]);
				text_bytes.push_back(code[7:0]);
			end else if (r < 82) begin
				text_bytes.push_back(8'($urandom_range(128, 255)));
				text_bytes.push_back(8'($urandom_range(128, 255)));
			end else if (r < 88) begin
				text_bytes.push_back($urandom_range(0, 1) ? tgl_pkg::CHAR_CR
					: tgl_pkg::CHAR_LF);
			end else begin
				// lead byte cut short by a 7-bit byte
				text_bytes.push_back(8'($urandom_range(128, 255)));
				text_bytes.push_back(8'($urandom_range(0, 127)));
			end
		end
		if ($urandom_range(0, 9) == 0)
			text_bytes.push_back(8'($urandom_range(128, 255)));
		terminated = ($urandom_range(0, 9) != 0);
		sx = ($urandom_range(0, 4) == 0) ? CW'($urandom_range(0, COORD_MASK))
			: CW'($urandom_range(0, panel.scr_w - 1));
		sy = ($urandom_range(0, 4) == 0) ? CW'($urandom_range(0, COORD_MASK))
			: CW'($urandom_range(0, panel.scr_h - 1));
		send_byte(text_bytes[0], 1'b1, terminated && text_bytes.size() == 1, sx, sy);
		for (int i = 1; i < text_bytes.size(); i++)
			send_plain(text_bytes[i], terminated && i == text_bytes.size() - 1);
	endtask

	task automatic send_noise(int unsigned n);
		repeat (n)
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
				$urandom_range(0, 9) == 0, CW'($urandom_range(0, COORD_MASK)),
				CW'($urandom_range(0, COORD_MASK)));
	endtask

	// ---------------- configuration ----------------

	task automatic wait_idle();
		text_if.valid <= 1'b0;
		burst_left = 0;
		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [tgl_pkg::CFG_IDX_W-1:0] index, int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value[tgl_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	task automatic load_config(panel_cfg_t c);
		wait_idle();
		write_reg(tgl_pkg::CFG_SCREEN_WIDTH, c.scr_w);
		write_reg(tgl_pkg::CFG_SCREEN_HEIGHT, c.scr_h);
		write_reg(tgl_pkg::CFG_FONT_WIDTH, c.fnt_w);
		write_reg(tgl_pkg::CFG_FONT_HEIGHT, c.fnt_h);
		write_reg(tgl_pkg::CFG_FONT_FIRST_CODE, c.code_lo);
		write_reg(tgl_pkg::CFG_FONT_LAST_CODE, c.code_hi);
		write_reg(tgl_pkg::CFG_HANZI_ENABLE, c.hz_en);
		write_reg(tgl_pkg::CFG_MONO_PANEL, c.mono);
		cfg_we <= 1'b0;
		panel.scr_w   = c.scr_w & COORD_MASK;
		panel.scr_h   = c.scr_h & COORD_MASK;
		panel.fnt_w   = c.fnt_w & 8'hFF;
		panel.fnt_h   = c.fnt_h & 8'hFF;
		panel.code_lo = c.code_lo & 16'hFFFF;
		panel.code_hi = c.code_hi & 16'hFFFF;
		panel.hz_en   = c.hz_en;
		panel.mono    = c.mono;
	endtask

	function automatic panel_cfg_t make_cfg(int unsigned sw, int unsigned sh, int unsigned fw,
			int unsigned fh, int unsigned lo, int unsigned hi, bit hz, bit mono);
		panel_cfg_t c;
		c.scr_w = sw;
		c.scr_h = sh;
		c.fnt_w = fw;
		c.fnt_h = fh;
		c.code_lo = lo;
		c.code_hi = hi;
		c.hz_en = hz;
		c.mono = mono;
		return c;
	endfunction

	function automatic panel_cfg_t random_cfg();
		panel_cfg_t c;
		c = make_cfg($urandom_range(8, 320), $urandom_range(8, 240), $urandom_range(1, 40),
			$urandom_range(1, 40), $urandom_range(0, 64), $urandom_range(64, 200),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0) begin
			c.fnt_w = tgl_pkg::MONO_SIZE;
			c.fnt_h = tgl_pkg::MONO_SIZE;
		end
		if ($urandom_range(0, 4) == 0)
			c.code_lo = $urandom_range(0, 16'hFFFF);
		if ($urandom_range(0, 4) == 0)
			c.code_hi = $urandom_range(c.code_lo, 16'hFFFF);
		return c;
	endfunction

	// ---------------- tests ----------------

	task automatic test_directed();
		load_config(make_cfg(tgl_pkg::SCREEN_WIDTH_RST, tgl_pkg::SCREEN_HEIGHT_RST,
			tgl_pkg::FONT_WIDTH_RST, tgl_pkg::FONT_HEIGHT_RST, tgl_pkg::FONT_FIRST_CODE_RST,
			tgl_pkg::FONT_LAST_CODE_RST, 1'b1, 1'b0));
		send_byte("A", 1'b1, 1'b0, 12'd5, 12'd3);
		send_plain(8'h7E, 1'b0);
		send_plain(8'h20, 1'b0);
		send_plain(8'h1F, 1'b0);
		send_plain(8'h00, 1'b0);
		send_plain(8'h7F, 1'b0);
		send_plain(tgl_pkg::CHAR_CR, 1'b0);
		send_plain(tgl_pkg::CHAR_LF, 1'b0);
		// first and last codes of the main area and of the punctuation table
		send_plain(tgl_pkg::HZ_LEAD_MIN, 1'b0);
		send_plain(tgl_pkg::HZ_TRAIL_MIN, 1'b0);
		send_plain(tgl_pkg::HZ_LEAD_MAX, 1'b0);
		send_plain(tgl_pkg::HZ_TRAIL_MAX, 1'b0);
		send_plain(tgl_pkg::PUNCT_CODES[0][15:8], 1'b0);
		send_plain(tgl_pkg::PUNCT_CODES[0][7:0], 1'b0);
		send_plain(tgl_pkg::PUNCT_CODES[tgl_pkg::PUNCT_N-1][15:8], 1'b0);
		send_plain(tgl_pkg::PUNCT_CODES[tgl_pkg::PUNCT_N-1][7:0], 1'b0);
		// high code outside both tables gives a blank
		send_plain(8'hA1, 1'b0);
		send_plain(8'hA4, 1'b0);
		// lone lead byte, then a two-byte code below the hanzi area
		send_plain(8'hC1, 1'b0);
		send_plain("x", 1'b0);
		send_plain(8'h81, 1'b0);
		send_plain(8'h81, 1'b0);
		// high byte as the final byte
		send_plain(8'hD5, 1'b1);
		// off-screen start clamps to the origin
		send_byte("Z", 1'b1, 1'b1, 12'hFFF, 12'hFFF);
	endtask

	task automatic test_mono_panel();
		load_config(make_cfg(96, 48, tgl_pkg::MONO_SIZE, tgl_pkg::MONO_SIZE, 0, 127, 1'b1,
			1'b1));
		repeat (6) send_string($urandom_range(3, 10));
		load_config(make_cfg(96, 48, tgl_pkg::MONO_SIZE, tgl_pkg::MONO_SIZE, 32, 126, 1'b0,
			1'b1));
		repeat (6) send_string($urandom_range(3, 10));
	endtask

	task automatic test_config_extremes();
		panel_cfg_t corner[4];
		corner[0] = make_cfg(1, 1, 1, 1, 0, 0, 1'b0, 1'b0);
		corner[1] = make_cfg(COORD_MASK, COORD_MASK, 255, 255, 0, 16'hFFFF, 1'b1, 1'b1);
		corner[2] = make_cfg(COORD_MASK, 1, 255, 1, 16'hFFFF, 0, 1'b1, 1'b0);
		corner[3] = make_cfg(1, COORD_MASK, 1, 255, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
		foreach (corner[k]) begin
			load_config(corner[k]);
			repeat (5) send_string($urandom_range(2, 12));
			send_noise(10);
		end
	endtask

	task automatic test_backpressure();
		load_config(make_cfg(160, 80, 8, 16, 32, 126, 1'b1, 1'b0));
		steady_tx = 1'b1;
		hold_requests++;
		while (holds_done != hold_requests) @(posedge clk);
		repeat (10) send_string($urandom_range(4, 8));
		steady_tx = 1'b0;
	endtask

	task automatic test_random();
		int unsigned target;
		int unsigned phase_end;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			load_config(random_cfg());
			phase_end = items_sent + $urandom_range(100, 250);
			if ($urandom_range(0, 3) == 0)
				hold_requests++;
			steady_tx = ($urandom_range(0, 2) == 0);
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0)
					send_noise($urandom_range(1, 8));
				else
					send_string($urandom_range(1, 12));
			end
			steady_tx = 1'b0;
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		text_if.valid      <= 1'b0;
		text_if.text_byte  <= 8'h00;
		text_if.first_byte <= 1'b0;
		text_if.last_byte  <= 1'b0;
		text_if.start_x    <= '0;
		text_if.start_y    <= '0;
		panel = make_cfg(tgl_pkg::SCREEN_WIDTH_RST, tgl_pkg::SCREEN_HEIGHT_RST,
			tgl_pkg::FONT_WIDTH_RST, tgl_pkg::FONT_HEIGHT_RST, tgl_pkg::FONT_FIRST_CODE_RST,
			tgl_pkg::FONT_LAST_CODE_RST, 1'b1, 1'b0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_mono_panel();
		test_config_extremes();
		test_backpressure();
		test_random();

		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/tgl_pkg.sv
rtl/core/tgl_in_if.sv
rtl/core/tgl_out_if.sv
rtl/core/tgl_glyph_pick.sv
rtl/core/tgl_advance.sv
rtl/core/text_glyph_layout.sv
rtl/core/tgl_checker.sv
dv/testbench.sv
